// ----- rtl/usvg_pkg.sv -----
`default_nettype none

package usvg_pkg;

    localparam int MAX_RINGS  = 256;
    localparam int MAX_SLICES = 256;

    localparam int CNT_W  = 9;
    localparam int IDX_W  = 17;
    localparam int TEX_W  = 17;
    localparam int POS_W  = 17;
    localparam int UNIT_W = 16;
    localparam int RAD_W  = 16;
    localparam int TRIG_W = 22;
    localparam int WIDE_W = 48;

    // long division: 33 quotient bits, divisor up to 2*256
    localparam int DIV_QW    = 33;
    localparam int DIV_DW    = 10;
    localparam int DIV_NW    = DIV_QW + DIV_DW;
    localparam int DIV_LANES = 4;

    localparam int LANE_PHI   = 0;
    localparam int LANE_THETA = 1;
    localparam int LANE_U     = 2;
    localparam int LANE_V     = 3;

    localparam int CORDIC_STEPS = 18;
    localparam int CORDIC_W     = 33;
    localparam int CORDIC_LAT   = CORDIC_STEPS + 2;
    localparam int POST_LAT     = 3;

    localparam logic signed [CORDIC_W-1:0] CORDIC_X0 = 33'sd652032874;

    // atan(2^-i) as a fraction of a turn, 2^32 per turn
    localparam logic signed [CORDIC_W-1:0] TURN_ATAN [CORDIC_STEPS] = '{
        33'sh020000000, 33'sh012E4051E, 33'sh009FB385B, 33'sh0051111D4,
        33'sh0028B0D43, 33'sh00145D7E1, 33'sh000A2F61E, 33'sh000517C55,
        33'sh00028BE53, 33'sh000145F2F, 33'sh0000A2F98, 33'sh0000517CC,
        33'sh000028BE6, 33'sh0000145F3, 33'sh00000A2FA, 33'sh00000517D,
        33'sh0000028BE, 33'sh00000145F
    };

    typedef enum logic {
        REQ_VERTEX = 1'b0,
        REQ_QUAD   = 1'b1
    } req_t;

    typedef logic [1:0] cfg_idx_t;
    localparam cfg_idx_t CFG_RING_COUNT    = 2'd0;
    localparam cfg_idx_t CFG_SLICE_COUNT   = 2'd1;
    localparam cfg_idx_t CFG_SPHERE_RADIUS = 2'd2;

    typedef logic signed [TRIG_W-1:0] trig_t;
    typedef logic signed [WIDE_W-1:0] wide_t;

    // side info that rides beside the divider
    typedef struct packed {
        req_t             kind;
        logic             pole;
        logic [IDX_W-1:0] idx0;
        logic [IDX_W-1:0] idx2;
    } quad_tag_t;

    // side info that rides beside the CORDIC and shading stages
    typedef struct packed {
        quad_tag_t        quad;
        logic [TEX_W-1:0] tex_u;
        logic [TEX_W-1:0] tex_v;
    } tail_tag_t;

    function automatic logic [CNT_W-1:0] count_clamp(input logic [CNT_W-1:0] v,
                                                      input int maxv);
        if (v == '0)
            return CNT_W'(1);
        else if (int'(v) > maxv)
            return CNT_W'(maxv);
        else
            return v;
    endfunction

    // round half up, then arithmetic shift
    function automatic wide_t rnd_shr(input wide_t v, input int n);
        return (v + (48'sd1 <<< (n - 1))) >>> n;
    endfunction

    function automatic logic signed [UNIT_W-1:0] sat_unit(input wide_t v);
        if (v > 48'sd16384)
            return 16'sd16384;
        else if (v < -48'sd16384)
            return -16'sd16384;
        else
            return v[UNIT_W-1:0];
    endfunction

    function automatic logic signed [POS_W-1:0] sat_pos(input wide_t v);
        if (v > 48'sd65535)
            return 17'sd65535;
        else if (v < -48'sd65535)
            return -17'sd65535;
        else
            return v[POS_W-1:0];
    endfunction

    function automatic trig_t sat_trig(input wide_t v);
        if (v > 48'sd1048576)
            return 22'sd1048576;
        else if (v < -48'sd1048576)
            return -22'sd1048576;
        else
            return v[TRIG_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ----- rtl/uv_sphere_vertex_generator.sv -----
`default_nettype none

// UV sphere vertex and index generator. A vertex request (req_type 0) for ring r and
// slice s returns one beat with position (Q8.8), unit normal and tangent (Q1.14) and
// texture coordinates (Q0.16); a quad request (req_type 1) returns six beats carrying
// the triangle indices of that quad, last_of_run marking the sixth. The pipeline takes
// one request per clock while in_ready is high; vertex requests stream at one per
// cycle while out_ready is high and a quad request holds the output for six beats.
// An input beat passes one input stage, 33 stages of the bit-per-stage divider that
// forms the angles and texture coordinates, 20 CORDIC stages, 3 scaling stages and
// the output register. An output stall freezes the pipe unless the slot in front of
// the output register is empty. Configuration writes (ring count, slice count, radius)
// are always accepted and must only be issued while the pipe is empty.
module uv_sphere_vertex_generator
    import usvg_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,

    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [1:0]               cfg_index,
    input  logic [RAD_W-1:0]         cfg_data,

    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic                     req_type,
    input  logic [CNT_W-1:0]         ring_index,
    input  logic [CNT_W-1:0]         slice_index,

    output logic                     out_valid,
    input  logic                     out_ready,
    output logic signed [POS_W-1:0]  pos_x,
    output logic signed [POS_W-1:0]  pos_y,
    output logic signed [POS_W-1:0]  pos_z,
    output logic signed [UNIT_W-1:0] norm_x,
    output logic signed [UNIT_W-1:0] norm_y,
    output logic signed [UNIT_W-1:0] norm_z,
    output logic signed [UNIT_W-1:0] tan_x,
    output logic signed [UNIT_W-1:0] tan_z,
    output logic [TEX_W-1:0]         tex_u,
    output logic [TEX_W-1:0]         tex_v,
    output logic [IDX_W-1:0]         vertex_index,
    output logic                     last_of_run
);

    localparam int       PIPE_LAT  = DIV_QW + CORDIC_LAT + POST_LAT;
    localparam int       TAIL_LAT  = CORDIC_LAT + POST_LAT;
    localparam int       BEAT_W    = 3;
    localparam logic [BEAT_W-1:0] LAST_BEAT = 3'd5;

    // configuration registers
    logic [CNT_W-1:0] ring_count_reg;
    logic [CNT_W-1:0] slice_count_reg;
    logic [RAD_W-1:0] sphere_radius_reg;
    logic [CNT_W-1:0] rings_eff;
    logic [CNT_W-1:0] slices_eff;

    // pipe control
    logic                tail_valid;
    logic                out_free;
    logic                load;
    logic                item_done;
    logic                pipe_en;
    logic [PIPE_LAT-1:0] vld_reg;

    // input stage
    req_t             in_kind;
    logic [CNT_W-1:0] r_lim;
    logic [CNT_W-1:0] s_lim;
    logic [CNT_W-1:0] r_sat;
    logic [CNT_W-1:0] s_sat;
    logic             s0_valid_reg;
    req_t             s0_kind_reg;
    logic [CNT_W-1:0] s0_r_reg;
    logic [CNT_W-1:0] s0_s_reg;
    logic             s0_pole_reg;

    logic [CNT_W:0]   stride;
    logic [IDX_W-1:0] idx0;
    quad_tag_t        qtag_in;
    quad_tag_t        qtag_d;
    tail_tag_t        ttag_in;
    tail_tag_t        ttag_d;

    logic [DIV_NW-1:0] div_num  [DIV_LANES];
    logic [DIV_DW-1:0] div_den  [DIV_LANES];
    logic [DIV_QW-1:0] div_quot [DIV_LANES];

    trig_t sin_phi, cos_phi, sin_theta, cos_theta;

    logic signed [POS_W-1:0]  p_x, p_y, p_z;
    logic signed [UNIT_W-1:0] n_x, n_y, n_z, t_x, t_z;

    // output register
    logic                     out_valid_reg;
    logic [BEAT_W-1:0]        beat_reg;
    req_t                     o_kind_reg;
    logic signed [POS_W-1:0]  o_px_reg, o_py_reg, o_pz_reg;
    logic signed [UNIT_W-1:0] o_nx_reg, o_ny_reg, o_nz_reg, o_tx_reg, o_tz_reg;
    logic [TEX_W-1:0]         o_u_reg, o_v_reg;
    logic [IDX_W-1:0]         o_idx0_reg, o_idx2_reg;
    logic [IDX_W-1:0]         quad_idx;

    // ---------------------------------------------------------------- config
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ring_count_reg    <= CNT_W'(16);
            slice_count_reg   <= CNT_W'(16);
            sphere_radius_reg <= RAD_W'(256);
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_RING_COUNT:    ring_count_reg    <= cfg_data[CNT_W-1:0];
                CFG_SLICE_COUNT:   slice_count_reg   <= cfg_data[CNT_W-1:0];
                CFG_SPHERE_RADIUS: sphere_radius_reg <= cfg_data;
                default:           ;
            endcase
        end
    end

    assign rings_eff  = count_clamp(ring_count_reg, MAX_RINGS);
    assign slices_eff = count_clamp(slice_count_reg, MAX_SLICES);

    // ---------------------------------------------------------- pipe control
    // Output register frees when empty or on the last beat of its item; the pipe
    // moves whenever that happens or the slot in front of it is empty.
    assign tail_valid = vld_reg[PIPE_LAT-1];
    assign item_done  = out_valid_reg && out_ready
                        && ((o_kind_reg == REQ_VERTEX) || (beat_reg == LAST_BEAT));
    assign out_free   = !out_valid_reg || item_done;
    assign load       = tail_valid && out_free;
    assign pipe_en    = out_free || !tail_valid;
    assign in_ready   = pipe_en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
            vld_reg      <= '0;
        end
        else if (pipe_en)
        begin
            s0_valid_reg <= in_valid;
            vld_reg      <= {vld_reg[PIPE_LAT-2:0], s0_valid_reg};
        end
    end

    // ----------------------------------------------------------- input stage
    // Vertex indices saturate to the count, quad indices to count-1.
    assign in_kind = req_t'(req_type);
    assign r_lim   = (in_kind == REQ_QUAD) ? rings_eff - CNT_W'(1) : rings_eff;
    assign s_lim   = (in_kind == REQ_QUAD) ? slices_eff - CNT_W'(1) : slices_eff;
    assign r_sat   = (ring_index > r_lim) ? r_lim : ring_index;
    assign s_sat   = (slice_index > s_lim) ? s_lim : slice_index;

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            s0_kind_reg <= in_kind;
            s0_r_reg    <= r_sat;
            s0_s_reg    <= s_sat;
            s0_pole_reg <= (r_sat == '0) || (r_sat == rings_eff);
        end
    end

    // quad corners: row stride is slices+1
    assign stride = {1'b0, slices_eff} + (CNT_W+1)'(1);
    assign idx0   = IDX_W'(s0_r_reg * stride) + IDX_W'(s0_s_reg);

    assign qtag_in.kind = s0_kind_reg;
    assign qtag_in.pole = s0_pole_reg;
    assign qtag_in.idx0 = idx0;
    assign qtag_in.idx2 = idx0 + IDX_W'(stride);

    // ---------------------------------------------------------------- divider
    // phi   = round(r * 2^31 / rings)   as (r*2^32 + rings) / (2*rings)
    // theta = round(s * 2^32 / slices)  mod 2^32
    // u, v  = round(s or r * 2^16 / count)
    assign div_num[LANE_PHI]   = (DIV_NW'(s0_r_reg) << 32) + DIV_NW'(rings_eff);
    assign div_den[LANE_PHI]   = {rings_eff, 1'b0};
    assign div_num[LANE_THETA] = (DIV_NW'(s0_s_reg) << 32) + DIV_NW'(slices_eff >> 1);
    assign div_den[LANE_THETA] = DIV_DW'(slices_eff);
    assign div_num[LANE_U]     = (DIV_NW'(s0_s_reg) << 16) + DIV_NW'(slices_eff >> 1);
    assign div_den[LANE_U]     = DIV_DW'(slices_eff);
    assign div_num[LANE_V]     = (DIV_NW'(s0_r_reg) << 16) + DIV_NW'(rings_eff >> 1);
    assign div_den[LANE_V]     = DIV_DW'(rings_eff);

    usvg_div u_div (
        .clk  (clk),
        .en   (pipe_en),
        .num  (div_num),
        .den  (div_den),
        .quot (div_quot)
    );

    usvg_delay #(
        .W     ($bits(quad_tag_t)),
        .DEPTH (DIV_QW)
    ) u_dly_div (
        .clk  (clk),
        .en   (pipe_en),
        .din  (qtag_in),
        .dout (qtag_d)
    );

    // ----------------------------------------------------------------- CORDIC
    usvg_cordic u_cordic_phi (
        .clk     (clk),
        .en      (pipe_en),
        .angle   (div_quot[LANE_PHI][31:0]),
        .sin_q20 (sin_phi),
        .cos_q20 (cos_phi)
    );

    usvg_cordic u_cordic_theta (
        .clk     (clk),
        .en      (pipe_en),
        .angle   (div_quot[LANE_THETA][31:0]),
        .sin_q20 (sin_theta),
        .cos_q20 (cos_theta)
    );

    assign ttag_in.quad  = qtag_d;
    assign ttag_in.tex_u = div_quot[LANE_U][TEX_W-1:0];
    assign ttag_in.tex_v = div_quot[LANE_V][TEX_W-1:0];

    usvg_delay #(
        .W     ($bits(tail_tag_t)),
        .DEPTH (TAIL_LAT)
    ) u_dly_tail (
        .clk  (clk),
        .en   (pipe_en),
        .din  (ttag_in),
        .dout (ttag_d)
    );

    // ---------------------------------------------------------------- scaling
    usvg_post u_post (
        .clk       (clk),
        .en        (pipe_en),
        .radius    (sphere_radius_reg),
        .sin_phi   (sin_phi),
        .cos_phi   (cos_phi),
        .sin_theta (sin_theta),
        .cos_theta (cos_theta),
        .pos_x     (p_x),
        .pos_y     (p_y),
        .pos_z     (p_z),
        .norm_x    (n_x),
        .norm_y    (n_y),
        .norm_z    (n_z),
        .tan_x     (t_x),
        .tan_z     (t_z)
    );

    // --------------------------------------------------------- output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            beat_reg      <= '0;
        end
        else if (out_free)
        begin
            out_valid_reg <= tail_valid;
            beat_reg      <= '0;
        end
        else if (out_valid_reg && out_ready)
        begin
            beat_reg <= beat_reg + BEAT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            o_kind_reg <= ttag_d.quad.kind;
            o_idx0_reg <= ttag_d.quad.idx0;
            o_idx2_reg <= ttag_d.quad.idx2;
            if (ttag_d.quad.kind == REQ_VERTEX)
            begin
                o_px_reg <= p_x;
                o_py_reg <= p_y;
                o_pz_reg <= p_z;
                o_nx_reg <= n_x;
                o_ny_reg <= n_y;
                o_nz_reg <= n_z;
                // tangent is undefined at the poles; report zero
                o_tx_reg <= ttag_d.quad.pole ? '0 : t_x;
                o_tz_reg <= ttag_d.quad.pole ? '0 : t_z;
                o_u_reg  <= ttag_d.tex_u;
                o_v_reg  <= ttag_d.tex_v;
            end
            else
            begin
                o_px_reg <= '0;
                o_py_reg <= '0;
                o_pz_reg <= '0;
                o_nx_reg <= '0;
                o_ny_reg <= '0;
                o_nz_reg <= '0;
                o_tx_reg <= '0;
                o_tz_reg <= '0;
                o_u_reg  <= '0;
                o_v_reg  <= '0;
            end
        end
    end

    // two triangles per quad: (a, d, c) and (a, b, d)
    always_comb
    begin
        case (beat_reg)
            3'd0:    quad_idx = o_idx0_reg;
            3'd1:    quad_idx = o_idx2_reg + IDX_W'(1);
            3'd2:    quad_idx = o_idx2_reg;
            3'd3:    quad_idx = o_idx0_reg;
            3'd4:    quad_idx = o_idx0_reg + IDX_W'(1);
            3'd5:    quad_idx = o_idx2_reg + IDX_W'(1);
            default: quad_idx = o_idx0_reg;
        endcase
    end

    assign out_valid    = out_valid_reg;
    assign pos_x        = o_px_reg;
    assign pos_y        = o_py_reg;
    assign pos_z        = o_pz_reg;
    assign norm_x       = o_nx_reg;
    assign norm_y       = o_ny_reg;
    assign norm_z       = o_nz_reg;
    assign tan_x        = o_tx_reg;
    assign tan_z        = o_tz_reg;
    assign tex_u        = o_u_reg;
    assign tex_v        = o_v_reg;
    assign vertex_index = (o_kind_reg == REQ_QUAD) ? quad_idx : '0;
    assign last_of_run  = (o_kind_reg == REQ_VERTEX) || (beat_reg == LAST_BEAT);

endmodule

`default_nettype wire

// ----- rtl/usvg_delay.sv -----
`default_nettype none

module usvg_delay #(
    parameter int W     = 8,
    parameter int DEPTH = 4
) (
    input  logic         clk,
    input  logic         en,
    input  logic [W-1:0] din,
    output logic [W-1:0] dout
);

    logic [W-1:0] tap_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tap_reg[0] <= din;
            for (int i = 1; i < DEPTH; i++)
            begin
                tap_reg[i] <= tap_reg[i-1];
            end
        end
    end

    assign dout = tap_reg[DEPTH-1];

endmodule

`default_nettype wire

// ----- rtl/usvg_div.sv -----
`default_nettype none

// Restoring divider, one quotient bit per stage, four lanes side by side. The
// user must keep configuration divisors steady while items are in flight; not enforced.
module usvg_div
    import usvg_pkg::*;
(
    input  logic              clk,
    input  logic              en,
    input  logic [DIV_NW-1:0] num  [DIV_LANES],
    input  logic [DIV_DW-1:0] den  [DIV_LANES],
    output logic [DIV_QW-1:0] quot [DIV_LANES]
);

    logic [DIV_DW-1:0] rem_reg [DIV_LANES][DIV_QW];
    logic [DIV_QW-1:0] low_reg [DIV_LANES][DIV_QW];
    logic [DIV_QW-1:0] q_reg   [DIV_LANES][DIV_QW];

    logic [DIV_DW-1:0] rem_in  [DIV_LANES][DIV_QW];
    logic [DIV_QW-1:0] low_in  [DIV_LANES][DIV_QW];
    logic [DIV_QW-1:0] q_in    [DIV_LANES][DIV_QW];
    logic [DIV_DW:0]   part    [DIV_LANES][DIV_QW];
    logic              fits    [DIV_LANES][DIV_QW];

    always_comb
    begin
        for (int ln = 0; ln < DIV_LANES; ln++)
        begin
            for (int k = 0; k < DIV_QW; k++)
            begin
                if (k == 0)
                begin
                    // top bits are below the divisor for every legal operand
                    rem_in[ln][k] = num[ln][DIV_NW-1:DIV_QW];
                    low_in[ln][k] = num[ln][DIV_QW-1:0];
                    q_in[ln][k]   = '0;
                end
                else
                begin
                    rem_in[ln][k] = rem_reg[ln][k-1];
                    low_in[ln][k] = low_reg[ln][k-1];
                    q_in[ln][k]   = q_reg[ln][k-1];
                end
                part[ln][k] = {rem_in[ln][k], low_in[ln][k][DIV_QW-1]};
                fits[ln][k] = part[ln][k] >= {1'b0, den[ln]};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int ln = 0; ln < DIV_LANES; ln++)
            begin
                for (int k = 0; k < DIV_QW; k++)
                begin
                    rem_reg[ln][k] <= fits[ln][k]
                                    ? DIV_DW'(part[ln][k] - {1'b0, den[ln]})
                                    : part[ln][k][DIV_DW-1:0];
                    low_reg[ln][k] <= {low_in[ln][k][DIV_QW-2:0], 1'b0};
                    q_reg[ln][k]   <= {q_in[ln][k][DIV_QW-2:0], fits[ln][k]};
                end
            end
        end
    end

    always_comb
    begin
        for (int ln = 0; ln < DIV_LANES; ln++)
        begin
            quot[ln] = q_reg[ln][DIV_QW-1];
        end
    end

endmodule

`default_nettype wire

// ----- rtl/usvg_cordic.sv -----
`default_nettype none

// Pipelined rotation CORDIC: fold stage, one stage per iteration, round stage.
module usvg_cordic
    import usvg_pkg::*;
(
    input  logic        clk,
    input  logic        en,
    input  logic [31:0] angle,
    output trig_t       sin_q20,
    output trig_t       cos_q20
);

    logic signed [CORDIC_W-1:0] x_reg [CORDIC_STEPS+1];
    logic signed [CORDIC_W-1:0] y_reg [CORDIC_STEPS+1];
    logic signed [CORDIC_W-1:0] z_reg [CORDIC_STEPS+1];
    logic                       exact_reg [CORDIC_STEPS+1];
    logic                       neg_reg   [CORDIC_STEPS+1];
    logic [1:0]                 quad_reg  [CORDIC_STEPS+1];
    trig_t                      sin_reg;
    trig_t                      cos_reg;

    logic                       fold;
    logic [31:0]                a_fold;
    logic signed [CORDIC_W-1:0] x_next [CORDIC_STEPS];
    logic signed [CORDIC_W-1:0] y_next [CORDIC_STEPS];
    logic signed [CORDIC_W-1:0] z_next [CORDIC_STEPS];
    logic signed [CORDIC_W-1:0] dx     [CORDIC_STEPS];
    logic signed [CORDIC_W-1:0] dy     [CORDIC_STEPS];
    logic signed [CORDIC_W-1:0] xs;
    logic signed [CORDIC_W-1:0] ys;
    trig_t                      cos_next;
    trig_t                      sin_next;

    // second and third quadrants: rotate by half a turn, negate at the end
    assign fold   = (angle[31:30] == 2'd1) || (angle[31:30] == 2'd2);
    assign a_fold = fold ? (angle ^ 32'h8000_0000) : angle;

    always_comb
    begin
        for (int i = 0; i < CORDIC_STEPS; i++)
        begin
            dx[i] = y_reg[i] >>> i;
            dy[i] = x_reg[i] >>> i;
            if (!z_reg[i][CORDIC_W-1])
            begin
                x_next[i] = x_reg[i] - dx[i];
                y_next[i] = y_reg[i] + dy[i];
                z_next[i] = z_reg[i] - TURN_ATAN[i];
            end
            else
            begin
                x_next[i] = x_reg[i] + dx[i];
                y_next[i] = y_reg[i] - dy[i];
                z_next[i] = z_reg[i] + TURN_ATAN[i];
            end
        end
    end

    always_comb
    begin
        xs = neg_reg[CORDIC_STEPS] ? -x_reg[CORDIC_STEPS] : x_reg[CORDIC_STEPS];
        ys = neg_reg[CORDIC_STEPS] ? -y_reg[CORDIC_STEPS] : y_reg[CORDIC_STEPS];
        if (exact_reg[CORDIC_STEPS])
        begin
            // multiples of a quarter turn are exact
            case (quad_reg[CORDIC_STEPS])
                2'd0:
                begin
                    cos_next = 22'sd1048576;
                    sin_next = '0;
                end
                2'd1:
                begin
                    cos_next = '0;
                    sin_next = 22'sd1048576;
                end
                2'd2:
                begin
                    cos_next = -22'sd1048576;
                    sin_next = '0;
                end
                default:
                begin
                    cos_next = '0;
                    sin_next = -22'sd1048576;
                end
            endcase
        end
        else
        begin
            cos_next = sat_trig(rnd_shr(WIDE_W'(xs), 10));
            sin_next = sat_trig(rnd_shr(WIDE_W'(ys), 10));
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0]     <= CORDIC_X0;
            y_reg[0]     <= '0;
            z_reg[0]     <= CORDIC_W'(signed'(a_fold));
            exact_reg[0] <= (angle[29:0] == '0);
            neg_reg[0]   <= fold;
            quad_reg[0]  <= angle[31:30];
            for (int i = 0; i < CORDIC_STEPS; i++)
            begin
                x_reg[i+1]     <= x_next[i];
                y_reg[i+1]     <= y_next[i];
                z_reg[i+1]     <= z_next[i];
                exact_reg[i+1] <= exact_reg[i];
                neg_reg[i+1]   <= neg_reg[i];
                quad_reg[i+1]  <= quad_reg[i];
            end
            cos_reg <= cos_next;
            sin_reg <= sin_next;
        end
    end

    assign sin_q20 = sin_reg;
    assign cos_q20 = cos_reg;

endmodule

`default_nettype wire

// ----- rtl/usvg_post.sv -----
`default_nettype none

// Products of the trig values, scaling by radius, rounding and clamping.
module usvg_post
    import usvg_pkg::*;
(
    input  logic                     clk,
    input  logic                     en,
    input  logic [RAD_W-1:0]         radius,
    input  trig_t                    sin_phi,
    input  trig_t                    cos_phi,
    input  trig_t                    sin_theta,
    input  trig_t                    cos_theta,
    output logic signed [POS_W-1:0]  pos_x,
    output logic signed [POS_W-1:0]  pos_y,
    output logic signed [POS_W-1:0]  pos_z,
    output logic signed [UNIT_W-1:0] norm_x,
    output logic signed [UNIT_W-1:0] norm_y,
    output logic signed [UNIT_W-1:0] norm_z,
    output logic signed [UNIT_W-1:0] tan_x,
    output logic signed [UNIT_W-1:0] tan_z
);

    localparam int PROD_W = 2 * TRIG_W;
    localparam int RADS_W = RAD_W + 1;
    localparam int PY_W   = RADS_W + TRIG_W;
    localparam int PQ_W   = 25;
    localparam int PR_W   = RADS_W + PQ_W;

    logic signed [RADS_W-1:0] rad_s;

    // stage 1
    logic signed [PROD_W-1:0] pxp_reg, pzp_reg;
    logic signed [PY_W-1:0]   pyr_reg;
    logic signed [UNIT_W-1:0] ny1_reg, tx1_reg, tz1_reg;
    // stage 2
    logic signed [PQ_W-1:0]   pxq, pzq;
    logic signed [PR_W-1:0]   pxr_reg, pzr_reg;
    logic signed [POS_W-1:0]  py2_reg;
    logic signed [UNIT_W-1:0] nx2_reg, nz2_reg, ny2_reg, tx2_reg, tz2_reg;
    // stage 3
    logic signed [POS_W-1:0]  px3_reg, py3_reg, pz3_reg;
    logic signed [UNIT_W-1:0] nx3_reg, ny3_reg, nz3_reg, tx3_reg, tz3_reg;

    assign rad_s = signed'({1'b0, radius});
    assign pxq   = PQ_W'(rnd_shr(WIDE_W'(pxp_reg), 20));
    assign pzq   = PQ_W'(rnd_shr(WIDE_W'(pzp_reg), 20));

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pxp_reg <= PROD_W'(sin_phi) * PROD_W'(sin_theta);
            pzp_reg <= PROD_W'(sin_phi) * (-PROD_W'(cos_theta));
            pyr_reg <= PY_W'(rad_s) * PY_W'(cos_phi);
            ny1_reg <= sat_unit(rnd_shr(WIDE_W'(cos_phi), 6));
            tx1_reg <= sat_unit(rnd_shr(WIDE_W'(cos_theta), 6));
            tz1_reg <= sat_unit(rnd_shr(WIDE_W'(sin_theta), 6));

            pxr_reg <= PR_W'(rad_s) * PR_W'(pxq);
            pzr_reg <= PR_W'(rad_s) * PR_W'(pzq);
            py2_reg <= sat_pos(rnd_shr(WIDE_W'(pyr_reg), 20));
            nx2_reg <= sat_unit(rnd_shr(WIDE_W'(pxp_reg), 26));
            nz2_reg <= sat_unit(rnd_shr(WIDE_W'(pzp_reg), 26));
            ny2_reg <= ny1_reg;
            tx2_reg <= tx1_reg;
            tz2_reg <= tz1_reg;

            px3_reg <= sat_pos(rnd_shr(WIDE_W'(pxr_reg), 20));
            pz3_reg <= sat_pos(rnd_shr(WIDE_W'(pzr_reg), 20));
            py3_reg <= py2_reg;
            nx3_reg <= nx2_reg;
            ny3_reg <= ny2_reg;
            nz3_reg <= nz2_reg;
            tx3_reg <= tx2_reg;
            tz3_reg <= tz2_reg;
        end
    end

    assign pos_x  = px3_reg;
    assign pos_y  = py3_reg;
    assign pos_z  = pz3_reg;
    assign norm_x = nx3_reg;
    assign norm_y = ny3_reg;
    assign norm_z = nz3_reg;
    assign tan_x  = tx3_reg;
    assign tan_z  = tz3_reg;

endmodule

`default_nettype wire
